### rtl/gtc_pkg.sv
// ----------------------------------------------------------------------------
// gtc_pkg: shared types and constants of the glyph text console renderer
// Word formats, configuration layout, command codes and default parameters.
// ----------------------------------------------------------------------------
package gtc_pkg;

  localparam int FONT_WIDTH_DEF      = 8;
  localparam int FONT_HEIGHT_DEF     = 8;
  localparam int MAX_GLYPHS_DEF      = 256;
  localparam int BYTES_PER_PIXEL_DEF = 4;

  localparam int CELL_GAP  = 2;
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic [15:0] CODE_NEWLINE = 16'd10;
  localparam logic [15:0] CODE_RETURN  = 16'd13;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_NEWLINE = 2'd1;
  localparam logic [1:0] OP_RETURN  = 2'd2;
  localparam logic [1:0] OP_DRAW    = 2'd3;

  localparam logic [2:0] REG_BASE_ADDRESS = 3'd0;
  localparam logic [2:0] REG_LINE_PITCH   = 3'd1;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FG_COLOR     = 3'd4;
  localparam logic [2:0] REG_BG_COLOR     = 3'd5;
  localparam logic [2:0] REG_GLYPH_LIMIT  = 3'd6;

  typedef struct packed {
    logic        mode;
    logic [15:0] char_code;
    logic [10:0] font_index;
    logic [7:0]  font_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pixel_address;
    logic [31:0] pixel_value;
    logic        last_pixel;
  } out_word_t;

  typedef struct packed {
    logic [31:0] base_address;
    logic [15:0] line_pitch;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
    logic [8:0]  glyph_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [8:0]  glyph;
    logic [10:0] font_index;
    logic [7:0]  font_byte;
  } cmd_t;

  localparam cfg_t CFG_RESET = '{
    base_address: 32'd0,
    line_pitch:   16'd4096,
    frame_width:  12'd1024,
    frame_height: 12'd768,
    fg_color:     32'h00ff_ffff,
    bg_color:     32'd0,
    glyph_limit:  9'd256
  };

endpackage

### rtl/gtc_fifo.sv
// ----------------------------------------------------------------------------
// gtc_fifo: small register queue
// Holds DEPTH words of WIDTH bits; the oldest word is shown while not empty.
// ----------------------------------------------------------------------------
module gtc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

### rtl/gtc_front.sv
// ----------------------------------------------------------------------------
// gtc_front: input classifier
// Sorts each input word into a font load, newline, carriage return or glyph
// draw, and resolves the glyph number of a draw.
// ----------------------------------------------------------------------------
module gtc_front #(
  parameter int MAX_GLYPHS = 256
) (
  input  gtc_pkg::in_word_t item,
  input  logic [8:0]        glyph_limit,
  output gtc_pkg::cmd_t     cmd
);
  import gtc_pkg::*;

  logic glyph_ok;

  assign glyph_ok = (item.char_code != 16'd0) &&
                    (item.char_code < {7'd0, glyph_limit}) &&
                    (item.char_code < 16'(MAX_GLYPHS));

  always_comb begin
    cmd.font_index = item.font_index;
    cmd.font_byte  = item.font_byte;
    cmd.glyph      = glyph_ok ? item.char_code[8:0] : 9'd0;
    if (!item.mode) begin
      cmd.op = OP_LOAD;
    end else if (item.char_code == CODE_NEWLINE) begin
      cmd.op = OP_NEWLINE;
    end else if (item.char_code == CODE_RETURN) begin
      cmd.op = OP_RETURN;
    end else begin
      cmd.op = OP_DRAW;
    end
  end

endmodule

### rtl/gtc_back.sv
// ----------------------------------------------------------------------------
// gtc_back: command executor
// Owns the font store and the cursor, and steps through the pixels of a glyph
// using incremental addresses: one pixel write per ST_PIX cycle unless full.
// ----------------------------------------------------------------------------
module gtc_back #(
  parameter int FONT_WIDTH      = 8,
  parameter int FONT_HEIGHT     = 8,
  parameter int MAX_GLYPHS      = 256,
  parameter int BYTES_PER_PIXEL = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  gtc_pkg::cfg_t      cfg,
  input  gtc_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output gtc_pkg::out_word_t word,
  output logic               word_push,
  input  logic               word_full
);
  import gtc_pkg::*;

  localparam int STORE_DEPTH = MAX_GLYPHS * FONT_HEIGHT;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int RW = (FONT_HEIGHT > 1) ? $clog2(FONT_HEIGHT) : 1;
  localparam int CW = (FONT_WIDTH > 1) ? $clog2(FONT_WIDTH) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_ROW   = 2'd2;
  localparam logic [1:0] ST_PIX   = 2'd3;

  logic [1:0]    state;
  logic [11:0]   cursor_col;
  logic [11:0]   cursor_row;
  logic [8:0]    glyph;
  logic [31:0]   ybase;
  logic [31:0]   xbase;
  logic [31:0]   line_addr;
  logic [31:0]   x_off;
  logic [31:0]   pix_addr;
  logic [AW-1:0] gbase;
  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [7:0]    font_store [STORE_DEPTH];
  logic [7:0]    rd_data;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [11:0]   row_inc;
  logic [11:0]   row_next;
  logic [11:0]   col_inc;
  logic          col_wrap;
  logic [2:0]    bit_idx;
  logic          row_end;
  logic          glyph_end;

  assign row_inc  = cursor_row + 12'd1;
  assign row_next = ({20'd0, cfg.frame_height} < (32'(row_inc) + 32'd1) *
                     32'(FONT_HEIGHT + CELL_GAP)) ? 12'd0 : row_inc;
  assign col_inc  = cursor_col + 12'd1;
  assign col_wrap = ({20'd0, cfg.frame_width} < (32'(col_inc) + 32'd1) *
                     32'(FONT_WIDTH + CELL_GAP));

  assign cmd_pop   = (state == ST_IDLE) && !cmd_empty;
  assign wr_en     = cmd_pop && (cmd.op == OP_LOAD) &&
                     (32'(cmd.font_index) < 32'(STORE_DEPTH));
  assign wr_addr   = AW'(cmd.font_index);
  assign rd_addr   = gbase + AW'(r);
  assign bit_idx   = 3'(7) - 3'(c);
  assign row_end   = (c == CW'(FONT_WIDTH - 1));
  assign glyph_end = row_end && (r == RW'(FONT_HEIGHT - 1));

  assign word_push          = (state == ST_PIX) && !word_full;
  assign word.pixel_address = pix_addr;
  assign word.pixel_value   = rd_data[bit_idx] ? cfg.fg_color : cfg.bg_color;
  assign word.last_pixel    = glyph_end;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_store[wr_addr] <= cmd.font_byte;
    end
    rd_data <= font_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor_col <= 12'd0;
      cursor_row <= 12'd0;
      r          <= '0;
      c          <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            case (cmd.op)
              OP_NEWLINE: cursor_row <= row_next;
              OP_RETURN:  cursor_col <= 12'd0;
              OP_DRAW: begin
                state <= ST_SETUP;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SETUP: begin
          r <= '0;
          if (col_wrap) begin
            cursor_col <= 12'd0;
            cursor_row <= row_next;
          end else begin
            cursor_col <= col_inc;
          end
          state <= ST_ROW;
        end
        ST_ROW: begin
          c     <= '0;
          state <= ST_PIX;
        end
        ST_PIX: begin
          if (word_push) begin
            if (glyph_end) begin
              state <= ST_IDLE;
            end else if (row_end) begin
              r     <= r + RW'(1);
              state <= ST_ROW;
            end else begin
              c <= c + CW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        glyph <= cmd.glyph;
        ybase <= 32'(cursor_row) * 32'(FONT_HEIGHT);
        xbase <= 32'(cursor_col) * 32'(FONT_WIDTH) + 32'd1;
      end
      ST_SETUP: begin
        line_addr <= cfg.base_address + 32'(ybase * 32'(cfg.line_pitch));
        x_off     <= 32'(xbase * 32'(BYTES_PER_PIXEL));
        gbase     <= AW'(32'(glyph) * 32'(FONT_HEIGHT));
      end
      ST_ROW: begin
        pix_addr <= line_addr + x_off;
      end
      ST_PIX: begin
        if (word_push) begin
          pix_addr <= pix_addr + 32'(BYTES_PER_PIXEL);
          if (row_end) begin
            line_addr <= line_addr + 32'(cfg.line_pitch);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/glyph_text_console_renderer_unit.sv
// ----------------------------------------------------------------------------
// glyph_text_console_renderer_unit: text console to framebuffer pixel writes
// A drawn character passes in the back end through a setup state, then for
// each glyph row through a row state, with one font store read, and a pixel
// state with one pixel write per cycle while the output queue has room.
// Font loads and cursor moves are done from the idle state. Synchronous reset
// clears the cursor and queues and sets the configuration registers to their
// defaults; the font store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module glyph_text_console_renderer_unit #(
  parameter int FONT_WIDTH      = gtc_pkg::FONT_WIDTH_DEF,
  parameter int FONT_HEIGHT     = gtc_pkg::FONT_HEIGHT_DEF,
  parameter int MAX_GLYPHS      = gtc_pkg::MAX_GLYPHS_DEF,
  parameter int BYTES_PER_PIXEL = gtc_pkg::BYTES_PER_PIXEL_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  gtc_pkg::in_word_t  item,
  output logic               empty,
  input  logic               pop,
  output gtc_pkg::out_word_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gtc_pkg::*;

  cfg_t      cfg;
  cmd_t      cmd_in;
  cmd_t      cmd_out;
  logic      cmd_empty;
  logic      cmd_pop;
  out_word_t word;
  logic      word_push;
  logic      word_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_ADDRESS: cfg.base_address <= cfg_data;
        REG_LINE_PITCH:   cfg.line_pitch   <= cfg_data[15:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[11:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[11:0];
        REG_FG_COLOR:     cfg.fg_color     <= cfg_data;
        REG_BG_COLOR:     cfg.bg_color     <= cfg_data;
        REG_GLYPH_LIMIT:  cfg.glyph_limit  <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  gtc_front #(
    .MAX_GLYPHS(MAX_GLYPHS)
  ) u_front (
    .item       (item),
    .glyph_limit(cfg.glyph_limit),
    .cmd        (cmd_in)
  );

  gtc_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .rdata(cmd_out),
    .empty(cmd_empty)
  );

  gtc_back #(
    .FONT_WIDTH     (FONT_WIDTH),
    .FONT_HEIGHT    (FONT_HEIGHT),
    .MAX_GLYPHS     (MAX_GLYPHS),
    .BYTES_PER_PIXEL(BYTES_PER_PIXEL)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd_out),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .word     (word),
    .word_push(word_push),
    .word_full(word_full)
  );

  gtc_fifo #(
    .WIDTH($bits(out_word_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (word_push),
    .wdata(word),
    .full (word_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

endmodule
